// ----- hw/rtl/complex_fixed_point_alu_core_defines.svh -----
// Assertion macros for the complex fixed-point ALU core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef COMPLEX_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define CFPA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication, held off during reset.
`define CFPA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CFPA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CFPA_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- hw/rtl/cfpa_pkg.sv -----
// Shared types and constants of the complex fixed-point ALU.
// Operation codes, angle format and the CORDIC arctangent table.
package cfpa_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ADD  = 3'd0;
  localparam kind_t KIND_SUB  = 3'd1;
  localparam kind_t KIND_MUL  = 3'd2;
  localparam kind_t KIND_DIV  = 3'd3;
  localparam kind_t KIND_CONJ = 3'd4;
  localparam kind_t KIND_MOD  = 3'd5;
  localparam kind_t KIND_ARG  = 3'd6;

  // Angle accumulator: Q5.30 with headroom for pi plus the sum of all steps
  localparam int ANG_W    = 35;
  localparam int ANG_FRAC = 30;
  typedef logic signed [ANG_W-1:0] angle_t;

  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

// ----- hw/rtl/cfpa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; stages past the quotient length only hold the result.
module cfpa_div #(
  parameter int MW  = 64,
  parameter int FB  = 16,
  parameter int LAT = 80
) (
  input  logic             clk,
  input  logic             en,
  input  logic [MW-1:0]    mag,
  input  logic [MW-1:0]    den,
  output logic [MW+FB-1:0] quo
);

  localparam int NQ = MW + FB;

  logic [MW-1:0] rem_r [LAT];
  logic [NQ-1:0] quo_r [LAT];
  logic [NQ-1:0] dvd_r [LAT];
  logic [MW-1:0] den_r [LAT];

  for (genvar j = 0; j < LAT; j++) begin : g_stage
    logic [MW-1:0] r_i;
    logic [NQ-1:0] q_i;
    logic [NQ-1:0] d_i;
    logic [MW-1:0] n_i;

    if (j == 0) begin : g_head
      assign r_i = '0;
      assign q_i = '0;
      assign d_i = {mag, {FB{1'b0}}};
      assign n_i = den;
    end else begin : g_tail
      assign r_i = rem_r[j-1];
      assign q_i = quo_r[j-1];
      assign d_i = dvd_r[j-1];
      assign n_i = den_r[j-1];
    end

    if (j < NQ) begin : g_step
      logic [MW:0] rr;
      logic        ge;
      always_comb begin
        rr = {r_i, d_i[NQ-1-j]};
        ge = (rr >= {1'b0, n_i});
      end
      // subtract when the divisor fits, shift the decision into the quotient
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? MW'(rr - {1'b0, n_i}) : rr[MW-1:0];
          quo_r[j] <= {q_i[NQ-2:0], ge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= r_i;
          quo_r[j] <= q_i;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[j] <= d_i;
        den_r[j] <= n_i;
      end
    end
  end

  assign quo = quo_r[LAT-1];

endmodule

// ----- hw/rtl/cfpa_cordic.sv -----
// Pipelined CORDIC in vectoring mode: angle of (x, y) in Q5.30.
// Depends on cfpa_pkg for the angle type and the arctangent table.
module cfpa_cordic #(
  parameter int OPW  = 32,
  parameter int ITER = 16,
  parameter int LAT  = 17
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [OPW-1:0] x0,
  input  logic signed [OPW-1:0] y0,
  output cfpa_pkg::angle_t      z,
  output logic                  zero
);

  import cfpa_pkg::*;

  localparam int CW = OPW + 3;

  logic signed [CW-1:0] x_r [LAT];
  logic signed [CW-1:0] y_r [LAT];
  angle_t               z_r [LAT];
  logic                 zf_r [LAT];

  for (genvar j = 0; j < LAT; j++) begin : g_stage
    if (j == 0) begin : g_pre
      logic signed [CW-1:0] xi;
      logic signed [CW-1:0] yi;
      always_comb begin
        xi = CW'(x0);
        yi = CW'(y0);
      end
      // turn a vector in the left half-plane by pi
      always_ff @(posedge clk) begin
        if (en) begin
          zf_r[j] <= (x0 == '0) && (y0 == '0);
          if (x0 < 0) begin
            x_r[j] <= -xi;
            y_r[j] <= -yi;
            z_r[j] <= (y0 >= 0) ? angle_t'(PI_Q30) : -angle_t'(PI_Q30);
          end else begin
            x_r[j] <= xi;
            y_r[j] <= yi;
            z_r[j] <= '0;
          end
        end
      end
    end else if (j <= ITER) begin : g_rot
      localparam int K = (j - 1) % 32;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      always_comb begin
        xs = x_r[j-1] >>> K;
        ys = y_r[j-1] >>> K;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          zf_r[j] <= zf_r[j-1];
          if (y_r[j-1] < 0) begin
            x_r[j] <= x_r[j-1] - ys;
            y_r[j] <= y_r[j-1] + xs;
            z_r[j] <= z_r[j-1] - angle_t'(ATAN_Q30[K]);
          end else begin
            x_r[j] <= x_r[j-1] + ys;
            y_r[j] <= y_r[j-1] - xs;
            z_r[j] <= z_r[j-1] + angle_t'(ATAN_Q30[K]);
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          zf_r[j] <= zf_r[j-1];
          x_r[j]  <= x_r[j-1];
          y_r[j]  <= y_r[j-1];
          z_r[j]  <= z_r[j-1];
        end
      end
    end
  end

  assign z    = z_r[LAT-1];
  assign zero = zf_r[LAT-1];

endmodule

// ----- hw/rtl/complex_fixed_point_alu_core.sv -----
// Complex-number ALU on signed fixed-point operands (Q16.16 by default): sum, difference,
// product, quotient, conjugate, modulus and argument, saturating with an overflow flag.
// One word is taken every clock cycle whenever the output register is free or being
// drained; results come out in order, through LAT + 5 register stages, where LAT is the
// longest bit-per-stage unit: the long divider, 2*OPW + FRAC_BITS stages (80 at the
// defaults), against OPW stages of square root and ANGLE_ITERATIONS + 1 of CORDIC. OPW is
// DATA_WIDTH capped at 32. A stall on the output freezes the whole pipeline, so nothing
// is dropped or repeated. Uses cfpa_pkg, cfpa_div and cfpa_cordic.
`include "complex_fixed_point_alu_core_defines.svh"
module complex_fixed_point_alu_core #(
  parameter int DATA_WIDTH       = 32,
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im (32 bits each, from bit 0)
  input  logic [2:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // real part, imaginary part (32 bits each, from bit 0)
  output logic [1:0]   m_tuser    // divide_by_zero, overflow
);

  import cfpa_pkg::*;

  localparam int OPW  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int PW2  = 2 * OPW;
  localparam int W2   = PW2 + 1;
  localparam int NQ   = PW2 + FRAC_BITS;
  localparam int RW   = W2 - FRAC_BITS;
  localparam int DIVL = NQ;
  localparam int SQL  = OPW;
  localparam int CORL = ANGLE_ITERATIONS + 1;
  localparam int LATA = (DIVL > SQL) ? DIVL : SQL;
  localparam int LAT  = (LATA > CORL) ? LATA : CORL;
  localparam int SH   = ANG_FRAC - FRAC_BITS;

  localparam logic [OPW-1:0]       OUT_MAX = {1'b0, {(OPW-1){1'b1}}};
  localparam logic [OPW-1:0]       OUT_MIN = {1'b1, {(OPW-1){1'b0}}};
  localparam logic signed [RW-1:0] PRE_MAX = $signed(RW'(OUT_MAX));
  localparam logic signed [RW-1:0] PRE_MIN = RW'($signed(OUT_MIN));
  localparam angle_t               ANG_MAX = $signed(ANG_W'(OUT_MAX));
  localparam angle_t               ANG_MIN = ANG_W'($signed(OUT_MIN));
  localparam angle_t               ANG_RND = $signed(ANG_W'((64'd1 << SH) >> 1));
  localparam logic [NQ-1:0]        LIM_Q   = NQ'(OUT_MIN);
  localparam logic [NQ-1:0]        MAX_Q   = NQ'(OUT_MAX);
  localparam logic signed [W2-1:0] HALF    = W2'((64'd1 << FRAC_BITS) >> 1);
  localparam logic [31:0]          SAT_HI  = 32'(OUT_MAX);
  localparam logic [31:0]          SAT_LO  = 32'($signed(OUT_MIN));

  typedef struct packed {
    kind_t                kind;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic signed [RW-1:0] pre_re;
    logic signed [RW-1:0] pre_im;
  } side_t;

  // one enable for every stage: advance whenever the output word can move
  logic en;
  logic out_v;
  assign en       = !out_v || m_tready;
  assign s_tready = en;

  // capture: take the low OPW bits of each operand as a signed value
  logic                  v0;
  kind_t                 k0;
  logic signed [OPW-1:0] ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0  <= s_tuser;
      ar0 <= $signed(s_tdata[OPW-1:0]);
      ai0 <= $signed(s_tdata[32 +: OPW]);
      br0 <= $signed(s_tdata[64 +: OPW]);
      bi0 <= $signed(s_tdata[96 +: OPW]);
    end
  end

  // products: every cross term and square, one multiplier each
  logic                  v1;
  kind_t                 k1;
  logic signed [OPW-1:0] ar1, ai1, br1, bi1;
  logic signed [PW2-1:0] p_rr, p_ii, p_ri, p_ir, q_ar, q_ai, q_br, q_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= k0;
      ar1  <= ar0;
      ai1  <= ai0;
      br1  <= br0;
      bi1  <= bi0;
      p_rr <= ar0 * br0;
      p_ii <= ai0 * bi0;
      p_ri <= ar0 * bi0;
      p_ir <= ai0 * br0;
      q_ar <= ar0 * ar0;
      q_ai <= ai0 * ai0;
      q_br <= br0 * br0;
      q_bi <= bi0 * bi0;
    end
  end

  // sums: product parts, quotient numerators, both sums of squares, short ops
  logic                  v2;
  kind_t                 k2;
  logic signed [OPW-1:0] ar2, ai2;
  logic signed [W2-1:0]  m_re2, m_im2, n_re2, n_im2;
  logic [PW2-1:0]        den2, msq2;
  logic signed [OPW:0]   e_re2, e_im2;
  logic signed [OPW:0]   e_re_nx, e_im_nx;

  always_comb begin
    case (k1)
      KIND_ADD: begin
        e_re_nx = (OPW+1)'(ar1) + (OPW+1)'(br1);
        e_im_nx = (OPW+1)'(ai1) + (OPW+1)'(bi1);
      end
      KIND_SUB: begin
        e_re_nx = (OPW+1)'(ar1) - (OPW+1)'(br1);
        e_im_nx = (OPW+1)'(ai1) - (OPW+1)'(bi1);
      end
      KIND_CONJ: begin
        e_re_nx = (OPW+1)'(ar1);
        e_im_nx = -(OPW+1)'(ai1);
      end
      default: begin
        e_re_nx = '0;
        e_im_nx = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2    <= k1;
      ar2   <= ar1;
      ai2   <= ai1;
      m_re2 <= W2'(p_rr) - W2'(p_ii);
      m_im2 <= W2'(p_ri) + W2'(p_ir);
      n_re2 <= W2'(p_rr) + W2'(p_ii);
      n_im2 <= W2'(p_ir) - W2'(p_ri);
      den2  <= PW2'(q_br) + PW2'(q_bi);
      msq2  <= PW2'(q_ar) + PW2'(q_ai);
      e_re2 <= e_re_nx;
      e_im2 <= e_im_nx;
    end
  end

  // prepare: round the product, split numerators into sign and magnitude
  logic                  v3;
  side_t                 side3, side3_nx;
  logic signed [OPW-1:0] ar3, ai3;
  logic [PW2-1:0]        mag_re3, mag_im3, den3, msq3;
  logic signed [W2-1:0]  rnd_re, rnd_im, abs_re, abs_im;

  always_comb begin
    // adding half then flooring rounds ties towards plus infinity on both signs
    rnd_re = (m_re2 + HALF) >>> FRAC_BITS;
    rnd_im = (m_im2 + HALF) >>> FRAC_BITS;
    abs_re = (n_re2 < 0) ? -n_re2 : n_re2;
    abs_im = (n_im2 < 0) ? -n_im2 : n_im2;
    side3_nx.kind   = k2;
    side3_nx.dz     = (den2 == '0);
    side3_nx.neg_re = (n_re2 < 0);
    side3_nx.neg_im = (n_im2 < 0);
    if (k2 == KIND_MUL) begin
      side3_nx.pre_re = rnd_re[RW-1:0];
      side3_nx.pre_im = rnd_im[RW-1:0];
    end else begin
      side3_nx.pre_re = RW'(e_re2);
      side3_nx.pre_im = RW'(e_im2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3   <= side3_nx;
      ar3     <= ar2;
      ai3     <= ai2;
      mag_re3 <= abs_re[PW2-1:0];
      mag_im3 <= abs_im[PW2-1:0];
      den3    <= den2;
      msq3    <= msq2;
    end
  end

  // long units run side by side, all LAT stages deep
  logic [NQ-1:0] quo_re, quo_im;
  angle_t        z_fin;
  logic          z_zero;

  cfpa_div #(.MW(PW2), .FB(FRAC_BITS), .LAT(LAT)) u_div_re (
    .clk (clk),
    .en  (en),
    .mag (mag_re3),
    .den (den3),
    .quo (quo_re)
  );

  cfpa_div #(.MW(PW2), .FB(FRAC_BITS), .LAT(LAT)) u_div_im (
    .clk (clk),
    .en  (en),
    .mag (mag_im3),
    .den (den3),
    .quo (quo_im)
  );

  cfpa_cordic #(.OPW(OPW), .ITER(ANGLE_ITERATIONS), .LAT(LAT)) u_cordic (
    .clk  (clk),
    .en   (en),
    .x0   (ar3),
    .y0   (ai3),
    .z    (z_fin),
    .zero (z_zero)
  );

  // square root, two radicand bits per stage, alongside the side-band and valid bits
  logic [PW2-1:0] sq_v [LAT];
  logic [OPW+1:0] sq_r [LAT];
  logic [OPW-1:0] sq_t [LAT];
  side_t          sd   [LAT];
  logic           vp   [LAT];

  for (genvar j = 0; j < LAT; j++) begin : g_unit
    logic [PW2-1:0] sv_i;
    logic [OPW+1:0] sr_i;
    logic [OPW-1:0] rt_i;
    side_t          sd_i;
    logic           v_i;

    if (j == 0) begin : g_head
      assign sv_i = msq3;
      assign sr_i = '0;
      assign rt_i = '0;
      assign sd_i = side3;
      assign v_i  = v3;
    end else begin : g_tail
      assign sv_i = sq_v[j-1];
      assign sr_i = sq_r[j-1];
      assign rt_i = sq_t[j-1];
      assign sd_i = sd[j-1];
      assign v_i  = vp[j-1];
    end

    if (j < SQL) begin : g_sq
      logic [OPW+3:0] rs;
      logic [OPW+3:0] tr;
      logic           ge;
      always_comb begin
        rs = {sr_i, sv_i[PW2-1-2*j -: 2]};
        tr = {2'b00, rt_i, 2'b01};
        ge = (rs >= tr);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[j] <= ge ? (OPW+2)'(rs - tr) : rs[OPW+1:0];
          sq_t[j] <= {rt_i[OPW-2:0], ge};
        end
      end
    end else begin : g_sq_hold
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[j] <= sr_i;
          sq_t[j] <= rt_i;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_v[j] <= sv_i;
        sd[j]   <= sd_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vp[j] <= 1'b0;
      end else if (en) begin
        vp[j] <= v_i;
      end
    end
  end

  // finish: saturate and pick the result of the requested operation
  function automatic logic [OPW:0] sat_pre(input logic signed [RW-1:0] v);
    logic [OPW:0] r;
    if (v > PRE_MAX) begin
      r = {1'b1, OUT_MAX};
    end else if (v < PRE_MIN) begin
      r = {1'b1, OUT_MIN};
    end else begin
      r = {1'b0, v[OPW-1:0]};
    end
    return r;
  endfunction

  // a quotient whose integer part is already out of range saturates on that part
  function automatic logic [OPW:0] div_fin(input logic [NQ-1:0] q, input logic neg);
    logic [PW2-1:0] qi;
    logic [NQ-1:0]  m;
    logic [NQ-1:0]  mn;
    logic [OPW:0]   r;
    qi = q[NQ-1:FRAC_BITS];
    m  = (|qi[PW2-1:OPW-1]) ? NQ'(qi) : q;
    mn = ~m + 1'b1;
    if (neg) begin
      r = (m > LIM_Q) ? {1'b1, OUT_MIN} : {1'b0, mn[OPW-1:0]};
    end else begin
      r = (m > MAX_Q) ? {1'b1, OUT_MAX} : {1'b0, m[OPW-1:0]};
    end
    return r;
  endfunction

  side_t          sdl;
  logic [OPW-1:0] root;
  logic [OPW:0]   f_re, f_im;
  angle_t         z_rnd;
  logic [OPW-1:0] re_nx, im_nx;
  logic           dz_nx, ov_nx;

  assign sdl  = sd[LAT-1];
  assign root = sq_t[LAT-1];

  always_comb begin
    z_rnd = (z_fin + ANG_RND) >>> SH;
    f_re  = '0;
    f_im  = '0;
    dz_nx = 1'b0;
    unique case (sdl.kind) inside
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_CONJ: begin
        f_re = sat_pre(sdl.pre_re);
        f_im = sat_pre(sdl.pre_im);
      end
      KIND_DIV: begin
        if (sdl.dz) begin
          dz_nx = 1'b1;
        end else begin
          f_re = div_fin(quo_re, sdl.neg_re);
          f_im = div_fin(quo_im, sdl.neg_im);
        end
      end
      KIND_MOD: begin
        f_re = root[OPW-1] ? {1'b1, OUT_MAX} : {1'b0, root};
      end
      KIND_ARG: begin
        if (z_zero) begin
          f_re = '0;
        end else if (z_rnd > ANG_MAX) begin
          f_re = {1'b1, OUT_MAX};
        end else if (z_rnd < ANG_MIN) begin
          f_re = {1'b1, OUT_MIN};
        end else begin
          f_re = {1'b0, z_rnd[OPW-1:0]};
        end
      end
      default: begin
        f_re = '0;
      end
    endcase
    re_nx = f_re[OPW-1:0];
    im_nx = f_im[OPW-1:0];
    ov_nx = f_re[OPW] | f_im[OPW];
  end

  // output register: hold the word until the sink takes it
  logic [OPW-1:0] out_re, out_im;
  logic           out_dz, out_ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= vp[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re <= re_nx;
      out_im <= im_nx;
      out_dz <= dz_nx;
      out_ov <= ov_nx;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {32'($signed(out_im)), 32'($signed(out_re))};
  assign m_tuser  = {out_ov, out_dz};

  // a zero divisor gives a clean zero word with no overflow
  `CFPA_ASSERT_IMP(a_dz_zero, clk, rst, m_tvalid && m_tuser[0],
                   (m_tdata == 64'd0) && !m_tuser[1])
  // overflow is only raised when some part sits at a saturation limit
  `CFPA_ASSERT_IMP(a_ov_limit, clk, rst, m_tvalid && m_tuser[1],
                   (m_tdata[31:0] == SAT_HI) || (m_tdata[31:0] == SAT_LO) ||
                   (m_tdata[63:32] == SAT_HI) || (m_tdata[63:32] == SAT_LO))
  // a waiting word stalls the input side
  `CFPA_ASSERT_IMP(a_stall, clk, rst, m_tvalid && !m_tready, !s_tready)
  // a drained word with nothing behind it leaves the output empty
  `CFPA_ASSERT_NXT(a_drain, clk, rst, m_tvalid && m_tready && !vp[LAT-1], !m_tvalid)

endmodule
